// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("assertion failed");

// Next-cycle implication, checked only while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("assertion failed");

`endif

// File: design/xsfb_pkg.sv
package xsfb_pkg;

  localparam int DEF_SCREEN_WIDTH  = 64;
  localparam int DEF_SCREEN_HEIGHT = 32;

  localparam int PIX_W     = 64;
  localparam int PIX_IDX_W = 6;
  localparam int BYTE_W    = 8;
  localparam int COORD_W   = 8;
  localparam int RIDX_W    = 4;
  localparam int REQ_W     = 2;

  localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

endpackage

// File: design/xsfb_mask.sv
module xsfb_mask #(
  parameter int SCREEN_WIDTH = xsfb_pkg::DEF_SCREEN_WIDTH
) (
  input  logic [xsfb_pkg::BYTE_W-1:0]  sprite_byte,
  input  logic [xsfb_pkg::COORD_W-1:0] x_pos,
  output logic [xsfb_pkg::PIX_W-1:0]   draw_mask
);
  import xsfb_pkg::*;

  localparam int COL_W   = $clog2(SCREEN_WIDTH);
  localparam int SUM_W   = COL_W + 1;
  localparam int TAB_N   = 1 << COORD_W;

  logic [COL_W-1:0] mod_tab [TAB_N];
  logic [COL_W-1:0] x_mod;

  for (genvar v = 0; v < TAB_N; v++) begin : g_mod
    assign mod_tab[v] = COL_W'(v % SCREEN_WIDTH);
  end

  assign x_mod = mod_tab[x_pos];

  // Eight consecutive columns are distinct provided the width is at least eight, which is not checked here.
  always_comb begin
    logic [SUM_W-1:0]     col_sum;
    logic [COL_W-1:0]     col;
    logic [PIX_IDX_W-1:0] pos;
    draw_mask = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      col_sum = {1'b0, x_mod} + SUM_W'(k);
      if (col_sum >= SUM_W'(SCREEN_WIDTH)) begin
        col_sum = col_sum - SUM_W'(SCREEN_WIDTH);
      end
      col = COL_W'(col_sum);
      pos = PIX_IDX_W'(PIX_W - 1) - PIX_IDX_W'(col);
      if (sprite_byte[BYTE_W-1-k]) begin
        draw_mask[pos] = 1'b1;
      end
    end
  end

endmodule

// File: design/xor_sprite_framebuffer_top.sv
// Results: a taken request beat passes the stage-1 and output registers, then strobes out_valid.
// Throughput: one request beat every cycle; busy stays low outside reset.
// The row store is a memory with a registered read port; per-row valid flags
// and a one-entry bypass of the last write keep back-to-back draws exact.
// Reset (synchronous, active low) empties the store and collision flag at once;
// busy is high while reset is asserted. The receiver cannot stall results.
`include "assert_macros.svh"

module xor_sprite_framebuffer_top #(
  parameter int SCREEN_WIDTH  = xsfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = xsfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [xsfb_pkg::REQ_W-1:0]   in_req_type,
  input  logic [xsfb_pkg::BYTE_W-1:0]  in_sprite_byte,
  input  logic [xsfb_pkg::COORD_W-1:0] in_x_pos,
  input  logic [xsfb_pkg::COORD_W-1:0] in_y_pos,
  input  logic [xsfb_pkg::RIDX_W-1:0]  in_row_index,
  input  logic                         in_last_row,
  output logic                         out_valid,
  output logic                         out_collision,
  output logic                         out_sprite_done,
  output logic [xsfb_pkg::PIX_W-1:0]   out_pixel_row
);
  import xsfb_pkg::*;

  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int YS_W  = COORD_W + 1;

  typedef struct packed {
    logic is_draw;
    logic is_clear;
    logic is_read;
    logic in_range;
    logic first_row;
    logic last_row;
  } s1_ctl_t;

  logic               in_fire;
  logic [YS_W-1:0]    row_sum;
  logic [YS_W-1:0]    sel_row;
  logic [ROW_W-1:0]   row_idx;
  logic [PIX_W-1:0]   draw_mask;
  s1_ctl_t            ctl_nxt;

  logic               s1_valid_r;
  s1_ctl_t            s1_ctl_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [PIX_W-1:0]   s1_mask_r;
  logic [PIX_W-1:0]   rd_data_r;

  logic [PIX_W-1:0]   frame_mem [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] row_vld_r;
  logic               fwd_en_r;
  logic [ROW_W-1:0]   fwd_row_r;
  logic [PIX_W-1:0]   fwd_data_r;
  logic               coll_r;

  logic [PIX_W-1:0]   old_row;
  logic [PIX_W-1:0]   new_row;
  logic               wr_en;
  logic               coll_nxt;

  logic               out_valid_r;
  logic               out_collision_r;
  logic               out_sprite_done_r;
  logic [PIX_W-1:0]   out_pixel_row_r;

  assign busy    = ~rst_n;
  assign in_fire = start & ~busy;

  assign row_sum = {1'b0, in_y_pos} + YS_W'(in_row_index);

  always_comb begin
    ctl_nxt = '0;
    sel_row = {1'b0, in_y_pos};
    ctl_nxt.first_row = (in_row_index == '0);
    ctl_nxt.last_row  = in_last_row;
    unique case (in_req_type)
      REQ_DRAW: begin
        ctl_nxt.is_draw  = 1'b1;
        sel_row          = row_sum;
        ctl_nxt.in_range = (row_sum < YS_W'(SCREEN_HEIGHT));
      end
      REQ_CLEAR: begin
        ctl_nxt.is_clear = 1'b1;
      end
      REQ_READ: begin
        ctl_nxt.is_read  = 1'b1;
        ctl_nxt.in_range = ({1'b0, in_y_pos} < YS_W'(SCREEN_HEIGHT));
      end
      default: begin
        ctl_nxt = '0;
      end
    endcase
  end

  assign row_idx = sel_row[ROW_W-1:0];

  xsfb_mask #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_mask (
    .sprite_byte(in_sprite_byte),
    .x_pos      (in_x_pos),
    .draw_mask  (draw_mask)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r  <= ctl_nxt;
    s1_row_r  <= row_idx;
    s1_mask_r <= draw_mask;
  end

  always_ff @(posedge clk) begin
    if (in_fire && ctl_nxt.in_range) begin
      rd_data_r <= frame_mem[row_idx];
    end
  end

  // A row written on the same edge as this beat's read comes from the bypass.
  always_comb begin
    old_row = '0;
    if (s1_ctl_r.in_range && row_vld_r[s1_row_r]) begin
      if (fwd_en_r && (fwd_row_r == s1_row_r)) begin
        old_row = fwd_data_r;
      end else begin
        old_row = rd_data_r;
      end
    end
  end

  assign new_row = old_row ^ s1_mask_r;
  assign wr_en   = s1_valid_r & s1_ctl_r.is_draw & s1_ctl_r.in_range;

  always_comb begin
    coll_nxt = coll_r;
    if (s1_valid_r && s1_ctl_r.is_draw) begin
      coll_nxt = (s1_ctl_r.first_row ? 1'b0 : coll_r) | (|(old_row & s1_mask_r));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[s1_row_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    fwd_row_r  <= s1_row_r;
    fwd_data_r <= new_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      fwd_en_r  <= 1'b0;
      coll_r    <= 1'b0;
    end else begin
      fwd_en_r <= wr_en;
      coll_r   <= coll_nxt;
      if (s1_valid_r && s1_ctl_r.is_clear) begin
        row_vld_r <= '0;
      end else if (wr_en) begin
        row_vld_r[s1_row_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_collision_r   <= s1_ctl_r.is_draw & coll_nxt;
    out_sprite_done_r <= s1_ctl_r.is_draw & s1_ctl_r.last_row;
    out_pixel_row_r   <= s1_ctl_r.is_read ? old_row : '0;
  end

  assign out_valid       = out_valid_r;
  assign out_collision   = out_collision_r;
  assign out_sprite_done = out_sprite_done_r;
  assign out_pixel_row   = out_pixel_row_r;

  `ASSERT_IMPL(a_latency, clk, rst_n, in_fire, ##2 out_valid)
  `ASSERT_IMPL(a_no_spurious, clk, rst_n, out_valid, $past(in_fire, 2))
  `ASSERT_IMPL(a_read_no_flags, clk, rst_n, out_valid && (out_pixel_row != '0), !out_collision && !out_sprite_done)
  `ASSERT_NEXT(a_clear_empties, clk, rst_n, s1_valid_r && s1_ctl_r.is_clear, (row_vld_r == '0))

endmodule
